[src/top_k_priority_selector_assert.svh]
// Assertion macros for the top-k priority selector checker
`ifndef TOP_K_PRIORITY_SELECTOR_ASSERT_SVH
`define TOP_K_PRIORITY_SELECTOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define TKPS_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("top_k_priority_selector check failed");

// next-cycle implication
`define TKPS_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("top_k_priority_selector check failed");

`endif

[src/tkps_pkg.sv]
// Shared types and constants for the top-k priority selector
package tkps_pkg;

  localparam int unsigned KeyW  = 16;
  localparam int unsigned BusW  = 16;
  localparam int unsigned StopW = 20;
  localparam int unsigned HourW = 5;
  localparam int unsigned DayW  = 2;
  localparam int unsigned RankW = 8;

  localparam logic [RankW-1:0] RANK_MAX = 8'd255;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [BusW-1:0]  bus;
    logic [StopW-1:0] stop;
    logic [HourW-1:0] hour;
    logic [DayW-1:0]  day;
  } rec_t;

  // operation applied to every cell this cycle
  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctl_t;

  // what a cell shows its neighbours
  typedef struct packed {
    rec_t rec;
    logic vld;
    logic gt;
  } cell_link_t;

endpackage

[src/tkps_cell.sv]
// One slot of the sorted list: compare against the new word, hold or shift
module tkps_cell
  import tkps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctl_t  ctl,
  input  rec_t       new_rec,
  input  cell_link_t left,
  input  cell_link_t right,
  output cell_link_t link
);

  rec_t rec;
  logic vld;
  logic gt;

  // empty slots always yield; ties keep the older entry in front
  assign gt = !vld || (new_rec.key > rec.key);

  assign link.rec = rec;
  assign link.vld = vld;
  assign link.gt  = gt;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ctl.pop) begin
      vld <= right.vld;
    end else if (ctl.ins && gt) begin
      vld <= left.gt ? left.vld : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      rec <= right.rec;
    end else if (ctl.ins && gt) begin
      rec <= left.gt ? left.rec : new_rec;
    end
  end

endmodule

[src/top_k_priority_selector.sv]
// Top-k priority selector: chain of compare-and-shift cells with a result register
//
//   channel | handshake          | payload
//   --------+--------------------+-----------------------------------------------
//   input   | in_valid/in_ready  | mode sat_key bus_id stop_id hour_of_day day_class
//   output  | out_valid/out_ready| rank_number top_key top_bus top_stop top_hour
//           |                    | top_day empty_flag
//
// One word per cycle while in_ready is high: every cell compares its key with the new
// key in parallel and shifts right (insert) or left (pop).
// A pop word shows its result in the cycle after acceptance, in the output register.
// in_ready drops only while a result waits and out_ready is low.
// rst clears all cell valid bits, the rank counter and out_valid; no clearing pass.
module top_k_priority_selector
  import tkps_pkg::*;
#(
  parameter int unsigned KEEP_DEPTH = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             mode,
  input  logic [KeyW-1:0]  sat_key,
  input  logic [BusW-1:0]  bus_id,
  input  logic [StopW-1:0] stop_id,
  input  logic [HourW-1:0] hour_of_day,
  input  logic [DayW-1:0]  day_class,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [RankW-1:0] rank_number,
  output logic [KeyW-1:0]  top_key,
  output logic [BusW-1:0]  top_bus,
  output logic [StopW-1:0] top_stop,
  output logic [HourW-1:0] top_hour,
  output logic [DayW-1:0]  top_day,
  output logic             empty_flag
);

  localparam cell_link_t EDGE_LINK = '0;

  logic       accept;
  cell_ctl_t  ctl;
  rec_t       new_rec;
  cell_link_t links [KEEP_DEPTH];
  logic [RankW-1:0] pop_counter;
  logic [RankW-1:0] pop_counter_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign ctl.ins  = accept && !mode;
  assign ctl.pop  = accept && mode && links[0].vld;

  assign new_rec.key  = sat_key;
  assign new_rec.bus  = bus_id;
  assign new_rec.stop = stop_id;
  assign new_rec.hour = hour_of_day;
  assign new_rec.day  = day_class;

  for (genvar i = 0; i < KEEP_DEPTH; i++) begin : g_cell
    cell_link_t left;
    cell_link_t right;
    if (i == 0) begin : g_head
      assign left = EDGE_LINK;
    end else begin : g_mid_l
      assign left = links[i-1];
    end
    if (i == KEEP_DEPTH - 1) begin : g_tail
      assign right = EDGE_LINK;
    end else begin : g_mid_r
      assign right = links[i+1];
    end
    tkps_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .new_rec (new_rec),
      .left    (left),
      .right   (right),
      .link    (links[i])
    );
  end

  // rank saturates at its maximum
  assign pop_counter_next = (pop_counter == RANK_MAX) ? pop_counter
                                                      : pop_counter + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pop_counter <= '0;
    end else if (ctl.ins) begin
      pop_counter <= '0;
    end else if (ctl.pop) begin
      pop_counter <= pop_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && mode) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && mode) begin
      if (links[0].vld) begin
        rank_number <= pop_counter_next;
        top_key     <= links[0].rec.key;
        top_bus     <= links[0].rec.bus;
        top_stop    <= links[0].rec.stop;
        top_hour    <= links[0].rec.hour;
        top_day     <= links[0].rec.day;
        empty_flag  <= 1'b0;
      end else begin
        rank_number <= '0;
        top_key     <= '0;
        top_bus     <= '0;
        top_stop    <= '0;
        top_hour    <= '0;
        top_day     <= '0;
        empty_flag  <= 1'b1;
      end
    end
  end

endmodule

[src/tkps_checker.sv]
// Port-level checks for the top-k priority selector, bound to the top level
`include "top_k_priority_selector_assert.svh"

module tkps_checker
  import tkps_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             mode,
  input logic             out_valid,
  input logic             out_ready,
  input logic [RankW-1:0] rank_number,
  input logic [KeyW-1:0]  top_key,
  input logic [BusW-1:0]  top_bus,
  input logic [StopW-1:0] top_stop,
  input logic [HourW-1:0] top_hour,
  input logic [DayW-1:0]  top_day,
  input logic             empty_flag
);

  // a stalled result word holds
  `TKPS_AST_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(top_key) && $stable(top_bus) && $stable(top_stop) && $stable(rank_number) && $stable(empty_flag))

  // empty pop gives an all-zero word
  `TKPS_AST_IMP(a_empty_zero, out_valid && empty_flag, rank_number == '0 && top_key == '0 && top_bus == '0 && top_stop == '0 && top_hour == '0 && top_day == '0)

  // a real pop always carries a rank of at least one
  `TKPS_AST_IMP(a_rank_nonzero, out_valid && !empty_flag, rank_number != '0)

  // only a pop word makes a result appear
  `TKPS_AST_IMP(a_rise_from_pop, $rose(out_valid), $past(in_valid && in_ready && mode))

  // input never blocked while the result register is free
  `TKPS_AST_IMP(a_ready_free, !out_valid, in_ready)

endmodule

bind top_k_priority_selector tkps_checker u_tkps_checker (.*);

[verif/tb.sv]
// Self-checking testbench for the top-k priority selector: directed and random words
`timescale 1ns / 100ps

module tb;
  import tkps_pkg::*;

  localparam int unsigned KEEP         = 128;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned RANDOM_WORDS = 900;
  localparam int unsigned IDLE_PCT     = 22;

  typedef enum logic {MODE_INSERT = 1'b0, MODE_POP = 1'b1} mode_e;
  typedef enum int {KEYS_WIDE, KEYS_NARROW, KEYS_HIGH} key_span_e;

  typedef struct {
    logic [RankW-1:0] rank;
    rec_t             rec;
    logic             empty;
  } pop_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             mode = MODE_INSERT;
  logic [KeyW-1:0]  sat_key = '0;
  logic [BusW-1:0]  bus_id = '0;
  logic [StopW-1:0] stop_id = '0;
  logic [HourW-1:0] hour_of_day = '0;
  logic [DayW-1:0]  day_class = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [RankW-1:0] rank_number;
  logic [KeyW-1:0]  top_key;
  logic [BusW-1:0]  top_bus;
  logic [StopW-1:0] top_stop;
  logic [HourW-1:0] top_hour;
  logic [DayW-1:0]  top_day;
  logic             empty_flag;

  // predicted contents of the list, largest key first
  rec_t             held_recs[$];
  logic [RankW-1:0] rank_ctr = '0;
  pop_result_t      due_results[$];
  pop_result_t      want;

  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_reqs = 0;
  int unsigned stall_seen = 0;
  int unsigned hold_left = 0;
  bit          calm = 1'b0;

  top_k_priority_selector #(.KEEP_DEPTH(KEEP)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .sat_key(sat_key), .bus_id(bus_id), .stop_id(stop_id),
    .hour_of_day(hour_of_day), .day_class(day_class),
    .out_valid(out_valid), .out_ready(out_ready),
    .rank_number(rank_number), .top_key(top_key), .top_bus(top_bus),
    .top_stop(top_stop), .top_hour(top_hour), .top_day(top_day),
    .empty_flag(empty_flag)
  );

  always #10 clk = ~clk;

  function automatic void list_insert(rec_t r);
    int pos;
    pos = held_recs.size();
    for (int i = 0; i < held_recs.size(); i++) begin
      if (held_recs[i].key < r.key) begin
        pos = i;
        break;
      end
    end
    rank_ctr = '0;
    if (held_recs.size() < KEEP) begin
      held_recs.insert(pos, r);
    end else if (pos < held_recs.size()) begin
      held_recs.insert(pos, r);
      held_recs.delete(KEEP);
    end
    // otherwise not above the smallest key: dropped
  endfunction

  function automatic pop_result_t list_pop();
    pop_result_t res;
    res.rank  = '0;
    res.rec   = '0;
    res.empty = 1'b1;
    if (held_recs.size() != 0) begin
      if (rank_ctr != RANK_MAX) rank_ctr = rank_ctr + 1'b1;
      res.rank  = rank_ctr;
      res.rec   = held_recs.pop_front();
      res.empty = 1'b0;
    end
    return res;
  endfunction

  function automatic rec_t mk_rec(logic [KeyW-1:0] k, logic [BusW-1:0] b,
                                  logic [StopW-1:0] s, logic [HourW-1:0] h,
                                  logic [DayW-1:0] d);
    rec_t r;
    r.key  = k;
    r.bus  = b;
    r.stop = s;
    r.hour = h;
    r.day  = d;
    return r;
  endfunction

  function automatic rec_t random_rec(key_span_e span);
    rec_t r;
    r.bus  = BusW'($urandom);
    r.stop = StopW'($urandom);
    // mostly legal hours and days, now and then anything the field holds
    r.hour = ($urandom_range(9) == 0) ? HourW'($urandom) : HourW'($urandom_range(23));
    r.day  = ($urandom_range(9) == 0) ? DayW'($urandom) : DayW'($urandom_range(2));
    case (span)
      KEYS_NARROW: r.key = KeyW'($urandom_range(15));
      KEYS_HIGH:   r.key = KeyW'($urandom_range(65535, 65000));
      default:     r.key = KeyW'($urandom);
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned exp_val);
    mismatches++;
    if (mismatches <= 100)
      $display("%0t ns: %s got %0h, expected %0h", $time, what, got, exp_val);
  endtask

  // in_valid is only lowered for a gap, so back-to-back words keep it high
  task automatic send_word(mode_e op, rec_t r);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid    <= 1'b1;
    mode        <= op;
    sat_key     <= r.key;
    bus_id      <= r.bus;
    stop_id     <= r.stop;
    hour_of_day <= r.hour;
    day_class   <= r.day;
    do @(posedge clk); while (!in_ready);
    if (op == MODE_INSERT) list_insert(r);
    else due_results.insert(due_results.size(), list_pop());
  endtask

  task automatic test_empty_pop();
    send_word(MODE_POP, random_rec(KEYS_WIDE));
    send_word(MODE_POP, random_rec(KEYS_WIDE));
    send_word(MODE_INSERT, random_rec(KEYS_WIDE));
    send_word(MODE_POP, random_rec(KEYS_WIDE));
    send_word(MODE_POP, random_rec(KEYS_WIDE));
  endtask

  task automatic test_field_extremes();
    send_word(MODE_INSERT, mk_rec(16'hFFFF, 16'h0000, 20'hFFFFF, 5'd0, 2'd0));
    send_word(MODE_INSERT, mk_rec(16'h0000, 16'hFFFF, 20'h00000, 5'd23, 2'd2));
    // hour and day beyond their nominal range come back unchanged
    send_word(MODE_INSERT, mk_rec(16'h8000, 16'hA5A5, 20'h5A5A5, 5'd31, 2'd3));
    send_word(MODE_INSERT, mk_rec(16'h0000, 16'h5A5A, 20'hA5A5A, 5'd24, 2'd1));
    send_word(MODE_POP, random_rec(KEYS_WIDE));
    send_word(MODE_POP, random_rec(KEYS_WIDE));
    send_word(MODE_INSERT, mk_rec(16'h7FFF, 16'h8000, 20'h80000, 5'd16, 2'd1));
    send_word(MODE_POP, random_rec(KEYS_WIDE));
    send_word(MODE_POP, random_rec(KEYS_WIDE));
    send_word(MODE_POP, random_rec(KEYS_WIDE));
    send_word(MODE_POP, random_rec(KEYS_WIDE));
  endtask

  task automatic test_equal_keys();
    send_word(MODE_INSERT, mk_rec(16'd100, 16'd1, 20'd11, 5'd1, 2'd0));
    send_word(MODE_INSERT, mk_rec(16'd100, 16'd2, 20'd12, 5'd2, 2'd1));
    send_word(MODE_INSERT, mk_rec(16'd100, 16'd3, 20'd13, 5'd3, 2'd2));
    send_word(MODE_INSERT, mk_rec(16'd200, 16'd4, 20'd14, 5'd4, 2'd0));
    send_word(MODE_INSERT, mk_rec(16'd100, 16'd5, 20'd15, 5'd5, 2'd1));
    send_word(MODE_INSERT, mk_rec(16'd50, 16'd6, 20'd16, 5'd6, 2'd2));
    repeat (3) send_word(MODE_POP, random_rec(KEYS_WIDE));
    // a fresh insert restarts the rank count
    send_word(MODE_INSERT, mk_rec(16'd100, 16'd7, 20'd17, 5'd7, 2'd0));
    repeat (5) send_word(MODE_POP, random_rec(KEYS_WIDE));
  endtask

  task automatic test_full_list();
    logic [KeyW-1:0] floor_key;
    repeat (KEEP) send_word(MODE_INSERT, mk_rec(KeyW'($urandom_range(60000, 1000)),
                                               BusW'($urandom), StopW'($urandom),
                                               HourW'($urandom_range(23)),
                                               DayW'($urandom_range(2))));
    floor_key = held_recs[held_recs.size()-1].key;
    // below and equal to the smallest key are dropped; one above pushes it out
    send_word(MODE_INSERT, mk_rec(floor_key - 1'b1, 16'hBEEF, 20'h1, 5'd1, 2'd1));
    send_word(MODE_INSERT, mk_rec(floor_key, 16'hCAFE, 20'h2, 5'd2, 2'd2));
    send_word(MODE_INSERT, mk_rec(floor_key + 1'b1, 16'hF00D, 20'h3, 5'd3, 2'd0));
    send_word(MODE_INSERT, mk_rec(16'hFFFF, 16'h1234, 20'h4, 5'd4, 2'd1));
    repeat (KEEP + 1) send_word(MODE_POP, random_rec(KEYS_WIDE));
  endtask

  task automatic test_backpressure();
    calm = 1'b1;
    repeat (12) send_word(MODE_INSERT, random_rec(KEYS_WIDE));
    stall_reqs++;
    repeat (30) send_word(MODE_POP, random_rec(KEYS_WIDE));
    calm = 1'b0;
  endtask

  task automatic test_random_mix();
    int unsigned sent;
    int unsigned phase_len;
    int unsigned ins_pct;
    key_span_e   span;
    mode_e       op;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      phase_len = $urandom_range(200, 60);
      case ($urandom_range(2))
        0:       ins_pct = 85;
        1:       ins_pct = 50;
        default: ins_pct = 20;
      endcase
      span = key_span_e'($urandom_range(2));
      calm = (sent >= 450 && sent < 750);
      for (int i = 0; i < phase_len && sent < RANDOM_WORDS; i++) begin
        if ($urandom_range(99) < ins_pct) op = MODE_INSERT;
        else op = MODE_POP;
        send_word(op, random_rec(span));
        sent++;
      end
    end
    calm = 1'b0;
  endtask

  // receiver: random stalls, calm stretches and a long hold on request
  always @(posedge clk) begin
    if (stall_reqs != stall_seen) begin
      stall_seen <= stall_reqs;
      hold_left  <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        report_mismatch("result word with none due", 1, 0);
      end else begin
        want = due_results.pop_front();
        if (empty_flag !== want.empty) report_mismatch("empty_flag", empty_flag, want.empty);
        if (rank_number !== want.rank) report_mismatch("rank_number", rank_number, want.rank);
        if (top_key !== want.rec.key) report_mismatch("top_key", top_key, want.rec.key);
        if (top_bus !== want.rec.bus) report_mismatch("top_bus", top_bus, want.rec.bus);
        if (top_stop !== want.rec.stop) report_mismatch("top_stop", top_stop, want.rec.stop);
        if (top_hour !== want.rec.hour) report_mismatch("top_hour", top_hour, want.rec.hour);
        if (top_day !== want.rec.day) report_mismatch("top_day", top_day, want.rec.day);
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_empty_pop();
    test_field_extremes();
    test_equal_keys();
    test_full_list();
    test_backpressure();
    test_random_mix();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    // catch any stray result word
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/tkps_pkg.sv
src/tkps_cell.sv
src/top_k_priority_selector.sv
src/tkps_checker.sv
verif/tb.sv
